>>> hdl/dtk_pkg.sv
// ----------------------------------------------------------------------------
// dtk_pkg: shared types for the top-K scan list
// Entry record and the compare request/reply passed to the compare unit.
// ----------------------------------------------------------------------------
`default_nettype none
package dtk_pkg;

  typedef struct packed {
    logic [15:0]       pan_id;
    logic [63:0]       ext_pan_id;
    logic signed [7:0] rssi;
    logic [15:0]       channel;
    logic [7:0]        version;
    logic [63:0]       ext_address;
    logic [7:0]        lqi;
  } entry_t;

  // Result of one comparison of the shared compare unit.
  typedef struct packed {
    logic id_match;   // pan ids and extended pan ids equal
    logic a_stronger; // rssi a > rssi b (signed)
    logic a_weaker;   // rssi a < rssi b (signed)
  } cmp_t;

endpackage
`default_nettype wire

>>> hdl/dtk_cmp.sv
// ----------------------------------------------------------------------------
// dtk_cmp: shared compare unit
// Identity match and signed strength compare of two entries.
// ----------------------------------------------------------------------------
`default_nettype none
module dtk_cmp (
  input  dtk_pkg::entry_t a,
  input  dtk_pkg::entry_t b,
  output dtk_pkg::cmp_t   res
);
  assign res.id_match   = (a.pan_id == b.pan_id) && (a.ext_pan_id == b.ext_pan_id);
  assign res.a_stronger = a.rssi > b.rssi;
  assign res.a_weaker   = a.rssi < b.rssi;
endmodule
`default_nettype wire

>>> hdl/dedup_top_k_by_signal.sv
// ----------------------------------------------------------------------------
// dedup_top_k_by_signal: bounded top-K scan list with de-duplication
// Keeps up to MAX_ENTRIES scan results sorted by descending rssi.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready): mode 0 inserts a scan result,
//    mode 1 emits the list in order and clears it.
//  - Output channel (out_valid/out_ready): one result per kept entry,
//    last on the final one; an empty list gives one result with
//    valid_res = 0, last = 1, other fields 0. Inserts give no result.
//  - A single compare unit is stepped by a sequencer over the list, one
//    entry per cycle: drop check (full list only), match scan, on a
//    stronger match a tail move and a sink pass of the moved tail (a
//    weaker or equal match drops the insert), the put and a bubble pass
//    of the new entry toward the head.
//  - An emit steps through the entries in order, each gated by
//    out_ready; a stalled receiver holds the result register and the
//    sequencer. in_ready is high only when the sequencer is idle.
//  - Reset clears the count and the sequencer; entry storage is not
//    cleared, since only entries below the count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none
module dedup_top_k_by_signal #(
  parameter int MAX_ENTRIES = 16
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire                mode,
  input  wire [15:0]         in_pan_id,
  input  wire [63:0]         in_ext_pan_id,
  input  wire signed [7:0]   in_rssi,
  input  wire [15:0]         in_channel,
  input  wire [7:0]          in_version,
  input  wire [63:0]         in_ext_address,
  input  wire [7:0]          in_lqi,
  output logic               out_valid,
  input  wire                out_ready,
  output logic               valid_res,
  output logic               last,
  output logic [15:0]        pan_id,
  output logic [63:0]        ext_pan_id,
  output logic signed [7:0]  rssi,
  output logic [15:0]        channel,
  output logic [7:0]         version,
  output logic [63:0]        ext_address,
  output logic [7:0]         lqi
);
  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] FULL = CW'(MAX_ENTRIES);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1; // full/drop check
  localparam logic [2:0] S_SCAN  = 3'd2; // match scan
  localparam logic [2:0] S_MOVE  = 3'd3; // move tail into matched slot
  localparam logic [2:0] S_PUT   = 3'd4; // write new entry at last slot
  localparam logic [2:0] S_SORT  = 3'd5; // bubble new entry up
  localparam logic [2:0] S_EMIT  = 3'd6;
  localparam logic [2:0] S_SINK  = 3'd7; // sink moved tail below stronger ones

  dtk_pkg::entry_t mem [MAX_ENTRIES];
  dtk_pkg::entry_t item, rd, tail;
  logic [2:0]      state;
  logic [CW-1:0]   count;
  logic [IW-1:0]   idx;
  dtk_pkg::entry_t cmp_a;
  dtk_pkg::entry_t cmp_b;
  dtk_pkg::cmp_t   cres;

  // one entry is read per cycle at the sequencer index
  assign rd = mem[idx];

  // sort compares item against the entry above it (idx-1);
  // sink compares the moved tail against the entry below it (idx+1)
  assign cmp_a = (state == S_SINK) ? tail : item;
  assign cmp_b = (state == S_SORT) ? mem[idx - IW'(1)] :
                 (state == S_SINK) ? mem[idx + IW'(1)] : rd;

  dtk_cmp u_cmp (.a(cmp_a), .b(cmp_b), .res(cres));

  assign in_ready = (state == S_IDLE);
  logic out_free;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      // the emit state drives out_valid itself
      if (out_valid && out_ready && state != S_EMIT) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item <= '{in_pan_id, in_ext_pan_id, in_rssi, in_channel,
                      in_version, in_ext_address, in_lqi};
            if (mode) begin
              idx   <= '0;
              state <= S_EMIT;
            end else begin
              idx   <= (count == FULL) ? IW'(count - CW'(1)) : '0;
              state <= (count == FULL) ? S_CHECK : S_SCAN;
            end
          end
        end
        S_CHECK: begin
          // idx points at the weakest entry
          if (rd.rssi > item.rssi) state <= S_IDLE;
          else begin
            idx   <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (CW'(idx) >= count) begin
            state <= S_PUT;
          end else if (cres.id_match) begin
            if (cres.a_stronger) begin
              tail  <= mem[IW'(count - CW'(1))];
              state <= S_MOVE;
            end else state <= S_IDLE;
          end else if (CW'(idx) == count - CW'(1)) begin
            state <= S_PUT;
          end else idx <= idx + IW'(1);
        end
        S_MOVE: begin
          mem[idx] <= tail;
          count    <= count - CW'(1);
          state    <= S_SINK;
        end
        S_SINK: begin
          // tail goes below strictly stronger entries, stays above equal ones
          if ((CW'(idx) + CW'(1) < count) && cres.a_weaker) begin
            mem[idx]          <= mem[idx + IW'(1)];
            mem[idx + IW'(1)] <= tail;
            idx               <= idx + IW'(1);
          end else state <= S_PUT;
        end
        S_PUT: begin
          if (count != FULL) begin
            mem[IW'(count)] <= item;
            idx             <= IW'(count);
            count           <= count + CW'(1);
          end else begin
            mem[IW'(count - CW'(1))] <= item;
            idx                      <= IW'(count - CW'(1));
          end
          state <= S_SORT;
        end
        S_SORT: begin
          // list minus item is sorted; strict compare keeps it stable
          if (idx != '0 && cres.a_stronger) begin
            mem[idx]          <= mem[idx - IW'(1)];
            mem[idx - IW'(1)] <= item;
            idx               <= idx - IW'(1);
          end else state <= S_IDLE;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (count == '0) begin
              valid_res   <= 1'b0;
              last        <= 1'b1;
              pan_id      <= '0;
              ext_pan_id  <= '0;
              rssi        <= '0;
              channel     <= '0;
              version     <= '0;
              ext_address <= '0;
              lqi         <= '0;
              state       <= S_IDLE;
            end else begin
              valid_res   <= 1'b1;
              last        <= (CW'(idx) == count - CW'(1));
              pan_id      <= rd.pan_id;
              ext_pan_id  <= rd.ext_pan_id;
              rssi        <= rd.rssi;
              channel     <= rd.channel;
              version     <= rd.version;
              ext_address <= rd.ext_address;
              lqi         <= rd.lqi;
              if (CW'(idx) == count - CW'(1)) begin
                count <= '0;
                state <= S_IDLE;
              end else idx <= idx + IW'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
